[sv/spk128_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speck128 core package
// Item types, register map constants and round helpers shared by the core.
// ----------------------------------------------------------------------------
package spk128_pkg;

	localparam int MAX_ROUNDS_DEF = 34;
	localparam int BASE_ROUNDS    = 32;
	localparam int WORD_W         = 64;
	localparam int ADDR_W         = 6;
	localparam int REG_IDX_W      = 3;

	localparam logic [REG_IDX_W-1:0] REG_VARIANT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY0    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEY1    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KEY2    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KEY3    = 3'd4;

	localparam logic [1:0] VAR_128 = 2'd0;
	localparam logic [1:0] VAR_192 = 2'd1;
	localparam logic [1:0] VAR_256 = 2'd2;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic  operation;
		word_t block_low;
		word_t block_high;
	} in_item_t;

	typedef struct packed {
		word_t out_low;
		word_t out_high;
	} out_item_t;

	typedef enum logic [1:0] {
		KS_IDLE,
		KS_LOAD,
		KS_RUN
	} ks_state_t;

	function automatic word_t ror8(input word_t v);
		return {v[7:0], v[WORD_W-1:8]};
	endfunction

	function automatic word_t rol8(input word_t v);
		return {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]};
	endfunction

	function automatic word_t ror3(input word_t v);
		return {v[2:0], v[WORD_W-1:3]};
	endfunction

	function automatic word_t rol3(input word_t v);
		return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
	endfunction

endpackage

[sv/speck128_block_cipher_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speck128 block cipher core
// Each accepted item passes through every pipeline stage before it reaches res_data.
// Throughput: one item per cycle, one round per stage of an unrolled pipeline,
// while the key schedule is idle and the output is not stalled. Each write to
// a mapped register restarts the key schedule; no item is accepted until it is done.
// Reset clears the pipeline valid bits and the configuration registers; the
// round key store holds no defined value until the first configuration write.
// ----------------------------------------------------------------------------
module speck128_block_cipher_core #(
	parameter int MAX_ROUNDS = spk128_pkg::MAX_ROUNDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            blk_valid,
	output logic                            blk_ready,
	input  spk128_pkg::in_item_t            blk_data,
	output logic                            res_valid,
	input  logic                            res_ready,
	output spk128_pkg::out_item_t           res_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [spk128_pkg::ADDR_W-1:0]   paddr,
	input  logic [spk128_pkg::WORD_W-1:0]   pwdata,
	output logic [spk128_pkg::WORD_W-1:0]   prdata,
	output logic                            pready
);

	localparam int IDX_W = $clog2(MAX_ROUNDS);
	localparam int CNT_W = $clog2(MAX_ROUNDS + 1);

	logic [1:0]                  variant_q;
	spk128_pkg::word_t           key_q [4];
	logic [1:0]                  var_code;
	logic [CNT_W-1:0]            rounds;
	logic                        cfg_wr;
	logic [spk128_pkg::REG_IDX_W-1:0] reg_idx;
	logic                        cfg_hit;

	spk128_pkg::ks_state_t       ks_state_q;
	spk128_pkg::ks_state_t       ks_state_nxt;
	logic                        ks_load;
	logic                        ks_step;
	logic                        ks_last;
	logic [IDX_W-1:0]            ks_i_q;
	spk128_pkg::word_t           ks_k_q;
	spk128_pkg::word_t           ks_l_q [3];
	spk128_pkg::word_t           ks_nl;
	spk128_pkg::word_t           ks_k_nxt;
	spk128_pkg::word_t           rk_q [MAX_ROUNDS];

	logic                        adv;
	logic                        pipe_vld_s [MAX_ROUNDS];
	logic                        pipe_op_s  [MAX_ROUNDS];
	spk128_pkg::word_t           pipe_x_s   [MAX_ROUNDS];
	spk128_pkg::word_t           pipe_y_s   [MAX_ROUNDS];

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[spk128_pkg::ADDR_W-1:spk128_pkg::ADDR_W-spk128_pkg::REG_IDX_W];

	always_comb begin
		unique case (reg_idx)
			spk128_pkg::REG_VARIANT: cfg_hit = 1'b1;
			spk128_pkg::REG_KEY0:    cfg_hit = 1'b1;
			spk128_pkg::REG_KEY1:    cfg_hit = 1'b1;
			spk128_pkg::REG_KEY2:    cfg_hit = 1'b1;
			spk128_pkg::REG_KEY3:    cfg_hit = 1'b1;
			default:                 cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= spk128_pkg::VAR_128;
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (reg_idx)
				spk128_pkg::REG_VARIANT: variant_q <= pwdata[1:0];
				spk128_pkg::REG_KEY0:    key_q[0]  <= pwdata;
				spk128_pkg::REG_KEY1:    key_q[1]  <= pwdata;
				spk128_pkg::REG_KEY2:    key_q[2]  <= pwdata;
				spk128_pkg::REG_KEY3:    key_q[3]  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			spk128_pkg::REG_VARIANT: prdata = {{(spk128_pkg::WORD_W-2){1'b0}}, variant_q};
			spk128_pkg::REG_KEY0:    prdata = key_q[0];
			spk128_pkg::REG_KEY1:    prdata = key_q[1];
			spk128_pkg::REG_KEY2:    prdata = key_q[2];
			spk128_pkg::REG_KEY3:    prdata = key_q[3];
			default:                 prdata = '0;
		endcase
	end

	// Code 3 behaves as the 256-bit variant.
	assign var_code = (variant_q == 2'd3) ? spk128_pkg::VAR_256 : variant_q;

	always_comb begin
		if (spk128_pkg::BASE_ROUNDS + int'(var_code) > MAX_ROUNDS) begin
			rounds = CNT_W'(MAX_ROUNDS);
		end else begin
			rounds = CNT_W'(spk128_pkg::BASE_ROUNDS) + CNT_W'(var_code);
		end
	end

	// Key schedule sequencer.
	assign ks_last = (CNT_W'(ks_i_q) + CNT_W'(2)) >= rounds;

	always_comb begin
		ks_state_nxt = ks_state_q;
		if (cfg_wr && cfg_hit) begin
			ks_state_nxt = spk128_pkg::KS_LOAD;
		end else begin
			unique case (ks_state_q)
				spk128_pkg::KS_IDLE: ks_state_nxt = spk128_pkg::KS_IDLE;
				spk128_pkg::KS_LOAD: ks_state_nxt = spk128_pkg::KS_RUN;
				spk128_pkg::KS_RUN: begin
					if (ks_last) begin
						ks_state_nxt = spk128_pkg::KS_IDLE;
					end
				end
				default:             ks_state_nxt = spk128_pkg::KS_IDLE;
			endcase
		end
	end

	always_comb begin
		ks_load = 1'b0;
		ks_step = 1'b0;
		unique case (ks_state_q)
			spk128_pkg::KS_IDLE: ;
			spk128_pkg::KS_LOAD: ks_load = 1'b1;
			spk128_pkg::KS_RUN:  ks_step = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_state_q <= spk128_pkg::KS_IDLE;
		end else begin
			ks_state_q <= ks_state_nxt;
		end
	end

	assign ks_nl    = (spk128_pkg::ror8(ks_l_q[0]) + ks_k_q)
	                  ^ {{(spk128_pkg::WORD_W-IDX_W){1'b0}}, ks_i_q};
	assign ks_k_nxt = spk128_pkg::rol3(ks_k_q) ^ ks_nl;

	always_ff @(posedge clk) begin
		if (ks_load) begin
			ks_k_q    <= key_q[0];
			ks_l_q[0] <= key_q[1];
			ks_l_q[1] <= key_q[2];
			ks_l_q[2] <= key_q[3];
			ks_i_q    <= '0;
			rk_q[0]   <= key_q[0];
		end else if (ks_step) begin
			ks_k_q <= ks_k_nxt;
			ks_i_q <= ks_i_q + IDX_W'(1);
			rk_q[ks_i_q + IDX_W'(1)] <= ks_k_nxt;
			case (var_code)
				spk128_pkg::VAR_128: begin
					ks_l_q[0] <= ks_nl;
				end
				spk128_pkg::VAR_192: begin
					ks_l_q[0] <= ks_l_q[1];
					ks_l_q[1] <= ks_nl;
				end
				default: begin
					ks_l_q[0] <= ks_l_q[1];
					ks_l_q[1] <= ks_l_q[2];
					ks_l_q[2] <= ks_nl;
				end
			endcase
		end
	end

	// Round pipeline: stage s holds round key s for encryption and round key
	// MAX_ROUNDS-1-s for decryption, and passes the item through unchanged when
	// that key index lies beyond the configured round count.
	assign adv       = !pipe_vld_s[MAX_ROUNDS-1] || res_ready;
	assign blk_ready = adv && (ks_state_q == spk128_pkg::KS_IDLE);

	for (genvar s = 0; s < MAX_ROUNDS; s++) begin : g_stage
		logic              src_vld;
		logic              src_op;
		spk128_pkg::word_t src_x;
		spk128_pkg::word_t src_y;
		spk128_pkg::word_t enc_x;
		spk128_pkg::word_t enc_y;
		spk128_pkg::word_t dec_x;
		spk128_pkg::word_t dec_y;
		spk128_pkg::word_t nxt_x;
		spk128_pkg::word_t nxt_y;
		logic              enc_act;
		logic              dec_act;

		if (s == 0) begin : g_src_in
			assign src_vld = blk_valid && blk_ready;
			assign src_op  = blk_data.operation;
			assign src_x   = blk_data.block_high;
			assign src_y   = blk_data.block_low;
		end else begin : g_src_prev
			assign src_vld = pipe_vld_s[s-1];
			assign src_op  = pipe_op_s[s-1];
			assign src_x   = pipe_x_s[s-1];
			assign src_y   = pipe_y_s[s-1];
		end

		assign enc_act = CNT_W'(s) < rounds;
		assign dec_act = CNT_W'(MAX_ROUNDS - 1 - s) < rounds;

		assign enc_x = (spk128_pkg::ror8(src_x) + src_y) ^ rk_q[s];
		assign enc_y = spk128_pkg::rol3(src_y) ^ enc_x;
		assign dec_y = spk128_pkg::ror3(src_y ^ src_x);
		assign dec_x = spk128_pkg::rol8((src_x ^ rk_q[MAX_ROUNDS-1-s]) - dec_y);

		always_comb begin
			nxt_x = src_x;
			nxt_y = src_y;
			if (src_op == spk128_pkg::OP_ENCRYPT) begin
				if (enc_act) begin
					nxt_x = enc_x;
					nxt_y = enc_y;
				end
			end else begin
				if (dec_act) begin
					nxt_x = dec_x;
					nxt_y = dec_y;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_vld_s[s] <= 1'b0;
			end else if (adv) begin
				pipe_vld_s[s] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_op_s[s] <= src_op;
				pipe_x_s[s]  <= nxt_x;
				pipe_y_s[s]  <= nxt_y;
			end
		end
	end

	assign res_valid         = pipe_vld_s[MAX_ROUNDS-1];
	assign res_data.out_low  = pipe_y_s[MAX_ROUNDS-1];
	assign res_data.out_high = pipe_x_s[MAX_ROUNDS-1];

endmodule
